@@ rtl/core/clws_pkg.sv @@
// ----------------------------------------------------------------------------
// clws_pkg
// Shared types and constants for the character LCD write sequencer.
// ----------------------------------------------------------------------------
package clws_pkg;

    localparam int LINE_LENGTH       = 16;
    localparam int SECOND_LINE_LIMIT = 18;

    localparam int FIRST_W  = 6;
    localparam int SECOND_W = $clog2(SECOND_LINE_LIMIT + 1);

    localparam logic [FIRST_W-1:0]  FIRST_MAX  = '1;
    localparam logic [FIRST_W-1:0]  LINE_LEN_C = FIRST_W'(LINE_LENGTH);
    localparam logic [SECOND_W-1:0] SEC_LIM_C  = SECOND_W'(SECOND_LINE_LIMIT);

    localparam logic [7:0] ADDR_LINE1 = 8'h80;
    localparam logic [7:0] ADDR_LINE2 = 8'hC0;
    localparam logic [7:0] CMD_CLEAR  = 8'h01;
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    // x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
    localparam int          NUM_DIGITS = 5;
    localparam int          DIGIT_IW   = $clog2(NUM_DIGITS);
    localparam logic [15:0] DIV10_MUL  = 16'hCCCD;
    localparam int          DIV10_SHR  = 19;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // request command codes
    localparam logic [2:0] CMD_RAW     = 3'd0;
    localparam logic [2:0] CMD_CHAR    = 3'd1;
    localparam logic [2:0] CMD_CHAR_AT = 3'd2;
    localparam logic [2:0] CMD_NUM     = 3'd3;
    localparam logic [2:0] CMD_NUM_AT  = 3'd4;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] value;
        logic        row;
        logic [7:0]  column;
    } t_in_item;

    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_RAW,
        OP_CHAR,
        OP_CHAR_AT
    } t_op_kind;

    // one character-level operation handed from front to back
    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] data;
        logic [7:0] addr;
        logic       last;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_RAW,
        B_ADDR,
        B_DATA,
        B_LINE2,
        B_CLEAR,
        B_HOME
    } t_back_state;

    function automatic logic [7:0] pos_addr(input logic row, input logic [7:0] col);
        logic [7:0] base;
        base = row ? ADDR_LINE2 : ADDR_LINE1;
        return base + col - 8'd1;
    endfunction

endpackage

@@ rtl/core/clws_queue.sv @@
// ----------------------------------------------------------------------------
// clws_queue
// Small FIFO of character operations between the front and back parts.
// ----------------------------------------------------------------------------
module clws_queue
    import clws_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_op       i_push_op,
    input  logic      i_pop,
    output t_op       o_pop_op,
    output t_q_status o_status
);

    t_op               r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr;
    logic [Q_AW-1:0]   r_rd;
    logic [Q_AW:0]     r_count;
    logic [Q_AW:0]     n_count;
    logic              w_push;
    logic              w_pop;

    assign o_status.full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_pop_op = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_op;
        end
    end

endmodule

@@ rtl/core/clws_front.sv @@
// ----------------------------------------------------------------------------
// clws_front
// Accepts requests, converts numbers to decimal digits and splits every
// defined request into character operations for the queue.
// ----------------------------------------------------------------------------
module clws_front
    import clws_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_op       o_push_op
);

    t_front_state        r_state;
    t_front_state        n_state;
    logic [15:0]         r_value;
    logic [3:0]          r_digits [NUM_DIGITS];
    logic [DIGIT_IW-1:0] r_idx;
    logic [DIGIT_IW-1:0] r_ndig;
    logic                r_pos;
    logic                r_row;
    logic [7:0]          r_col;

    logic                w_accept;
    logic                w_is_num;
    logic [31:0]         w_prod;
    logic [15:0]         w_quot;
    logic [15:0]         w_rem;
    logic [DIGIT_IW-1:0] w_ndig;

    assign o_in_stall = (r_state != F_IDLE) || i_q_status.full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_is_num   = (i_in_data.command == CMD_NUM) || (i_in_data.command == CMD_NUM_AT);

    // one decimal digit per cycle, least significant first
    assign w_prod = 32'(r_value) * 32'(DIV10_MUL);
    assign w_quot = 16'(w_prod >> DIV10_SHR);
    assign w_rem  = r_value - ((w_quot << 3) + (w_quot << 1));
    assign w_ndig = (r_value != '0) ? r_idx + 1'b1 : r_ndig;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (w_accept && w_is_num) begin
                    n_state = F_DIV;
                end
            end
            F_DIV: begin
                if (r_idx == DIGIT_IW'(NUM_DIGITS - 1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_status.full && r_idx == '0) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_push    = 1'b0;
        o_push_op = '{kind: OP_RAW, data: i_in_data.value[7:0],
                      addr: pos_addr(i_in_data.row, i_in_data.column), last: 1'b1};
        unique case (r_state)
            F_IDLE: begin
                unique case (i_in_data.command)
                    CMD_RAW: begin
                        o_push = w_accept;
                    end
                    CMD_CHAR: begin
                        o_push         = w_accept;
                        o_push_op.kind = OP_CHAR;
                    end
                    CMD_CHAR_AT: begin
                        o_push         = w_accept;
                        o_push_op.kind = OP_CHAR_AT;
                    end
                    default: o_push = 1'b0;
                endcase
            end
            F_PUSH: begin
                o_push         = !i_q_status.full;
                o_push_op.kind = r_pos ? OP_CHAR_AT : OP_CHAR;
                o_push_op.data = ASCII_ZERO + 8'(r_digits[r_idx]);
                o_push_op.addr = pos_addr(r_row, r_col);
                o_push_op.last = (r_idx == '0);
            end
            default: o_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            F_IDLE: begin
                r_value <= i_in_data.value;
                r_pos   <= (i_in_data.command == CMD_NUM_AT);
                r_row   <= i_in_data.row;
                r_col   <= i_in_data.column;
                r_idx   <= '0;
                r_ndig  <= DIGIT_IW'(1);
            end
            F_DIV: begin
                r_digits[r_idx] <= w_rem[3:0];
                r_value         <= w_quot;
                r_ndig          <= w_ndig;
                if (r_idx == DIGIT_IW'(NUM_DIGITS - 1)) begin
                    r_idx <= w_ndig - 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            F_PUSH: begin
                if (!i_q_status.full) begin
                    r_col <= r_col + 8'd1;
                    r_idx <= r_idx - 1'b1;
                end
            end
            default: r_idx <= '0;
        endcase
    end

endmodule

@@ rtl/core/clws_back.sv @@
// ----------------------------------------------------------------------------
// clws_back
// Carries out character operations as bus writes and keeps the two line
// counters that force the move to line two and the clear and home.
// ----------------------------------------------------------------------------
module clws_back
    import clws_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_q_status i_q_status,
    input  t_op       i_pop_op,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_back_state         r_state;
    t_back_state         n_state;
    t_op                 r_op;
    logic [FIRST_W-1:0]  r_first;
    logic [SECOND_W-1:0] r_second;
    logic                r_ovalid;
    t_out_item           r_odata;

    logic                w_can_emit;
    logic                w_emit;
    t_out_item           w_item;
    logic [FIRST_W-1:0]  w_first_inc;
    logic [SECOND_W-1:0] w_second_inc;
    logic                w_need_l2;
    logic                w_need_clr;

    assign w_can_emit   = !r_ovalid || !i_out_stall;
    assign w_first_inc  = (r_first == FIRST_MAX) ? r_first : r_first + 1'b1;
    assign w_second_inc = r_second + 1'b1;
    assign w_need_l2    = (w_first_inc >= LINE_LEN_C);
    assign w_need_clr   = (w_second_inc >= SEC_LIM_C);
    assign o_pop        = (r_state == B_IDLE) && !i_q_status.empty;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_status.empty) begin
                    unique case (i_pop_op.kind)
                        OP_RAW:     n_state = B_RAW;
                        OP_CHAR:    n_state = B_DATA;
                        OP_CHAR_AT: n_state = B_ADDR;
                        default:    n_state = B_IDLE;
                    endcase
                end
            end
            B_RAW: begin
                if (w_can_emit) n_state = B_IDLE;
            end
            B_ADDR: begin
                if (w_can_emit) n_state = B_DATA;
            end
            B_DATA: begin
                if (w_can_emit) n_state = w_need_l2 ? B_LINE2 : B_IDLE;
            end
            B_LINE2: begin
                if (w_can_emit) n_state = w_need_clr ? B_CLEAR : B_IDLE;
            end
            B_CLEAR: begin
                if (w_can_emit) n_state = B_HOME;
            end
            B_HOME: begin
                if (w_can_emit) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        w_emit = 1'b0;
        w_item = '{is_data: 1'b0, bus_byte: r_op.data, last: 1'b0};
        unique case (r_state)
            B_IDLE: begin
                w_emit = 1'b0;
            end
            B_RAW: begin
                w_emit      = 1'b1;
                w_item.last = r_op.last;
            end
            B_ADDR: begin
                w_emit          = 1'b1;
                w_item.bus_byte = r_op.addr;
            end
            B_DATA: begin
                w_emit         = 1'b1;
                w_item.is_data = 1'b1;
                w_item.last    = r_op.last && !w_need_l2;
            end
            B_LINE2: begin
                w_emit          = 1'b1;
                w_item.bus_byte = ADDR_LINE2 + 8'(r_second);
                w_item.last     = r_op.last && !w_need_clr;
            end
            B_CLEAR: begin
                w_emit          = 1'b1;
                w_item.bus_byte = CMD_CLEAR;
            end
            B_HOME: begin
                w_emit          = 1'b1;
                w_item.bus_byte = ADDR_LINE1;
                w_item.last     = r_op.last;
            end
            default: w_emit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_first  <= '0;
            r_second <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit && w_can_emit) begin
                r_ovalid <= 1'b1;
                unique case (r_state)
                    B_DATA:  r_first  <= w_first_inc;
                    B_LINE2: r_second <= w_second_inc;
                    B_HOME: begin
                        r_first  <= '0;
                        r_second <= '0;
                    end
                    default: r_first <= r_first;
                endcase
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= i_pop_op;
        end
        if (w_emit && w_can_emit) begin
            r_odata <= w_item;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule

@@ rtl/core/char_lcd_write_sequencer.sv @@
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer
// Turns display requests into character LCD bus writes (register select and
// one byte per transaction).
//
// Input channel: i_in_valid / o_in_stall carry one request per transaction
// (raw command, character, positioned character, number, positioned number).
// Output channel: o_out_valid / i_out_stall carry one bus write per
// transaction; last marks the final write of a request.
// The front takes a raw or character request directly; a number first
// passes a divide phase for its digits, then pushes them most significant first.
// The back end pops each character operation and then issues its writes
// one after another. A four-deep operation queue lets the front take
// the next request while writes are still draining.
// Reset clears both line counters, the queue and the output valid flag.
// A stalled output holds its write; the back end then stops, the queue
// fills, and the input stalls.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer
    import clws_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_q_status w_q_status;
    logic      w_push;
    t_op       w_push_op;
    logic      w_pop;
    t_op       w_pop_op;

    clws_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_push_op  (w_push_op)
    );

    clws_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_push_op (w_push_op),
        .i_pop     (w_pop),
        .o_pop_op  (w_pop_op),
        .o_status  (w_q_status)
    );

    clws_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (w_q_status),
        .i_pop_op    (w_pop_op),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

@@ tb/clws_write_checker.sv @@
// ----------------------------------------------------------------------------
// clws_write_checker
// Watches both channels of the character LCD write sequencer. It predicts the
// bus writes of every accepted request from its own copy of the two line
// counters, and compares each accepted write with the oldest predicted one.
// ----------------------------------------------------------------------------
module clws_write_checker
    import clws_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_writes_seen
);

    t_out_item             want_writes[$];
    logic [FIRST_W-1:0]    first_cnt;
    logic [SECOND_W-1:0]   second_cnt;
    int                    fail_cnt    = 0;
    int                    writes_seen = 0;

    task automatic report_mismatch(input string msg);
        fail_cnt++;
        $display("MISMATCH: %s", msg);
    endtask

    function automatic void add_write(input logic is_data, input logic [7:0] wr_byte);
        t_out_item w;
        w.is_data  = is_data;
        w.bus_byte = wr_byte;
        w.last     = 1'b0;
        want_writes.push_back(w);
    endfunction

    function automatic void show_char(input logic [7:0] ch);
        add_write(1'b1, ch);
        if (first_cnt != FIRST_MAX)
            first_cnt = first_cnt + 1'b1;
        // line one is full: every further character moves the cursor to line two
        if (first_cnt >= LINE_LENGTH) begin
            add_write(1'b0, ADDR_LINE2 + 8'(second_cnt));
            second_cnt = second_cnt + 1'b1;
        end
        if (second_cnt >= SECOND_LINE_LIMIT) begin
            add_write(1'b0, CMD_CLEAR);
            add_write(1'b0, ADDR_LINE1);
            first_cnt  = '0;
            second_cnt = '0;
        end
    endfunction

    function automatic void show_char_at(input logic [7:0] ch, input logic row,
                                         input logic [7:0] col);
        logic [7:0] addr;
        addr = (row ? ADDR_LINE2 : ADDR_LINE1) + col - 8'd1;
        add_write(1'b0, addr);
        show_char(ch);
    endfunction

    function automatic void show_number(input logic [15:0] num, input logic at_pos,
                                        input logic row, input logic [7:0] col);
        logic [3:0]  digits [0:NUM_DIGITS-1];
        logic [15:0] rest;
        int          n;
        int          k;
        rest = num;
        n    = 0;
        if (rest == 16'd0) begin
            digits[0] = 4'd0;
            n = 1;
        end
        while (rest != 16'd0) begin
            digits[n] = 4'(rest % 16'd10);
            rest      = rest / 16'd10;
            n++;
        end
        // most significant digit first; positioned digits step the column
        for (k = n - 1; k >= 0; k--) begin
            if (at_pos) begin
                show_char_at(ASCII_ZERO + 8'(digits[k]), row, col);
                col = col + 8'd1;
            end else begin
                show_char(ASCII_ZERO + 8'(digits[k]));
            end
        end
    endfunction

    function automatic void predict_bus_writes(input t_in_item req);
        int        n_prior;
        t_out_item tail;
        n_prior = want_writes.size();
        case (req.command)
            CMD_RAW:     add_write(1'b0, req.value[7:0]);
            CMD_CHAR:    show_char(req.value[7:0]);
            CMD_CHAR_AT: show_char_at(req.value[7:0], req.row, req.column);
            CMD_NUM:     show_number(req.value, 1'b0, req.row, req.column);
            CMD_NUM_AT:  show_number(req.value, 1'b1, req.row, req.column);
            default:     ;
        endcase
        if (want_writes.size() > n_prior) begin
            tail      = want_writes[want_writes.size() - 1];
            tail.last = 1'b1;
            want_writes[want_writes.size() - 1] = tail;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            want_writes.delete();
            first_cnt  = '0;
            second_cnt = '0;
        end else begin
            if (i_in_valid && !i_in_stall)
                predict_bus_writes(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                writes_seen++;
                if (want_writes.size() == 0) begin
                    report_mismatch($sformatf("unexpected write rs=%b byte=%02h last=%b",
                        i_out_data.is_data, i_out_data.bus_byte, i_out_data.last));
                end else begin
                    want = want_writes.pop_front();
                    if (i_out_data.is_data !== want.is_data ||
                        i_out_data.bus_byte !== want.bus_byte ||
                        i_out_data.last !== want.last)
                        report_mismatch($sformatf(
                            "write %0d: got rs=%b byte=%02h last=%b, want rs=%b byte=%02h last=%b",
                            writes_seen, i_out_data.is_data, i_out_data.bus_byte,
                            i_out_data.last, want.is_data, want.bus_byte, want.last));
                end
            end
        end
        o_fail_count  <= fail_cnt;
        o_pending     <= want_writes.size();
        o_writes_seen <= writes_seen;
    end

endmodule

@@ tb/tb_char_lcd_write_sequencer.sv @@
// ----------------------------------------------------------------------------
// tb_char_lcd_write_sequencer
// Drives display requests into the write sequencer: a directed set covering
// field extremes, every command, column wrap and unused codes, then random
// requests under four mixes of sender idling and receiver stalling. The
// checker beside the block predicts and compares every bus write.
// ----------------------------------------------------------------------------
module tb_char_lcd_write_sequencer;
    import clws_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 99;
    localparam int DRAIN_CYCLES  = 40;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    int fail_count;
    int pending;
    int writes_seen;
    int cycle_count = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int sent_count  = 0;
    int unused_count = 0;

    char_lcd_write_sequencer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    clws_write_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_writes_seen (writes_seen)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d writes outstanding",
                     cycle_count, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic t_in_item make_req(input logic [2:0] cmd, input logic [15:0] val,
                                          input logic row, input logic [7:0] col);
        t_in_item r;
        r.command = cmd;
        r.value   = val;
        r.row     = row;
        r.column  = col;
        return r;
    endfunction

    function automatic t_in_item random_req();
        t_in_item r;
        int       pick;
        r.value  = 16'($urandom_range(16'hFFFF));
        r.row    = 1'($urandom_range(1));
        r.column = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                            : 8'($urandom_range(1, 20));
        pick = $urandom_range(99);
        if (pick < 4)       r.command = 3'($urandom_range(int'(CMD_NUM_AT) + 1, 7));
        else if (pick < 18) r.command = CMD_RAW;
        else if (pick < 48) r.command = CMD_CHAR;
        else if (pick < 68) r.command = CMD_CHAR_AT;
        else if (pick < 86) r.command = CMD_NUM;
        else                r.command = CMD_NUM_AT;
        // spread numbers over every digit count
        if (r.command == CMD_NUM || r.command == CMD_NUM_AT) begin
            case ($urandom_range(3))
                0: r.value = 16'($urandom_range(9));
                1: r.value = 16'($urandom_range(99));
                2: r.value = 16'($urandom_range(9999));
                default: ;
            endcase
        end
        return r;
    endfunction

    // hold the request until the transaction completes
    task automatic send_req(input t_in_item req);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_stall);
        if (req.command > CMD_NUM_AT)
            unused_count++;
        else
            sent_count++;
    endtask

    task automatic random_phase(input int idle, input int stall);
        int target;
        idle_pct  = idle;
        stall_pct = stall;
        target    = sent_count + PHASE_ITEMS;
        while (sent_count < target)
            send_req(random_req());
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_req(make_req(CMD_RAW,     16'h0000, 1'b0, 8'd0));
        send_req(make_req(CMD_RAW,     16'hABFF, 1'b1, 8'd255));
        send_req(make_req(CMD_CHAR,    16'h0041, 1'b0, 8'd1));
        send_req(make_req(CMD_CHAR,    16'hFF00, 1'b1, 8'd0));
        send_req(make_req(CMD_CHAR,    16'h00FF, 1'b0, 8'd0));
        send_req(make_req(CMD_CHAR_AT, 16'h0042, 1'b0, 8'd1));
        send_req(make_req(CMD_CHAR_AT, 16'h0043, 1'b1, 8'd1));
        // column zero and the top column wrap the address
        send_req(make_req(CMD_CHAR_AT, 16'h0044, 1'b0, 8'd0));
        send_req(make_req(CMD_CHAR_AT, 16'hFFFF, 1'b1, 8'd255));
        send_req(make_req(CMD_NUM,     16'd0,     1'b0, 8'd0));
        send_req(make_req(CMD_NUM,     16'hFFFF,  1'b1, 8'd255));
        send_req(make_req(CMD_NUM,     16'd9,     1'b0, 8'd1));
        send_req(make_req(CMD_NUM,     16'd10,    1'b0, 8'd1));
        send_req(make_req(CMD_NUM,     16'd100,   1'b1, 8'd7));
        send_req(make_req(CMD_NUM_AT,  16'd12345, 1'b1, 8'd255));
        send_req(make_req(CMD_NUM_AT,  16'd0,     1'b0, 8'd0));
        send_req(make_req(CMD_NUM_AT,  16'd65535, 1'b0, 8'd253));
        send_req(make_req(3'd5,        16'hFFFF,  1'b1, 8'd255));
        send_req(make_req(3'd6,        16'h1234,  1'b0, 8'd1));
        send_req(make_req(3'd7,        16'h0000,  1'b1, 8'd0));

        random_phase(0, 0);
        random_phase(55, 0);
        random_phase(0, 55);
        random_phase(15, 15);

        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests and %0d unused codes under four idle/stall mixes",
                 sent_count, unused_count);
        $display("Checked %0d bus writes, %0d mismatches", writes_seen, fail_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/clws_pkg.sv
rtl/core/clws_queue.sv
rtl/core/clws_front.sv
rtl/core/clws_back.sv
rtl/core/char_lcd_write_sequencer.sv
tb/clws_write_checker.sv
tb/tb_char_lcd_write_sequencer.sv
